### design/box_downsample_2x2_mirror_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 box downsampler
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_2X2_MIRROR_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_MIRROR_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BDS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that implies another in the next cycle.
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg
// Types and constants of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    localparam int DIM_W = 11;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int BLK_W = $clog2(LINE_DEPTH);
    localparam int PIX_W = 8;
    localparam int SUM_W = PIX_W + 1;
    localparam int DST_W = 9;

    typedef enum logic [0:0] {
        CFG_SRC_WIDTH  = 1'b0,
        CFG_SRC_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_in_req;

    typedef struct packed {
        logic [PIX_W-1:0] avg_pixel;
        logic [DST_W-1:0] dst_col;
        logic [DST_W-1:0] dst_row;
        logic             last;
    } t_out_req;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [BLK_W-1:0] addr;
        logic [SUM_W-1:0] wdata;
    } t_ram_req;

endpackage

`default_nettype wire

### design/bds_line_ram.sv
// ----------------------------------------------------------------------------
// bds_line_ram
// Single-port line store with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bds_line_ram
    import bds_pkg::*;
#(
    parameter int DEPTH = LINE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire t_ram_req         i_req,
    output logic [SUM_W-1:0]      o_rdata
);

    logic [SUM_W-1:0] r_mem [DEPTH];
    logic [SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[$clog2(DEPTH)-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr[$clog2(DEPTH)-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/box_downsample_2x2_mirror.sv
// ----------------------------------------------------------------------------
// box_downsample_2x2_mirror
// Averages 2x2 blocks of a grey raster stream into a half-size frame whose
// columns are mirrored, using a line store of horizontal pair sums.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   i_in_data  (t_in_req)
//  output    out        o_out_valid / i_out_stall o_out_data (t_out_req)
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  One pixel is taken every clock while o_in_stall is low; the single
//  line-store port does one access per odd-column pixel in range, a
//  write on even rows or a read on odd rows. A result is registered in
//  the read stage, then in the output register. Input stalls only while
//  the read stage holds a result and the output register holds a stalled
//  one. Reset needs no clearing pass: the line store is not initialized.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "box_downsample_2x2_mirror_macros.svh"

module box_downsample_2x2_mirror
    import bds_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_req          i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_req              o_out_data,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_idx         i_cfg_idx,
    input  wire logic [DIM_W-1:0] i_cfg_data
);

    logic [DIM_W-1:0] r_src_width;
    logic [DIM_W-1:0] r_src_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_held;

    logic             r_s1_valid;
    logic [SUM_W-1:0] r_s1_pair;
    logic [DST_W-1:0] r_s1_dcol;
    logic [DST_W-1:0] r_s1_drow;
    logic             r_s1_last;

    logic             r_out_valid;
    t_out_req         r_out;

    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-2:0] half_w;
    logic [DIM_W-2:0] half_h;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0;
    logic             c_wrap;
    logic [COL_W-1:0] c1;
    logic [ROW_W:0]   r1;
    logic [ROW_W-1:0] r2;
    logic [BLK_W-1:0] blk;
    logic [DST_W-1:0] drow;
    logic [SUM_W-1:0] pair;
    logic             odd_col;
    logic             in_range;
    logic             row_ok;
    logic [COL_W:0]   c_inc;
    logic [ROW_W:0]   r3;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic             in_acc;
    logic             out_blocked;
    logic             re_flag;
    logic             we_flag;
    logic [SUM_W:0]   sum4;
    logic [SUM_W-1:0] rdata;
    t_ram_req         ram_req;

    always_comb begin
        priority if (r_src_width < DIM_W'(2)) begin
            w = DIM_W'(2);
        end else if (r_src_width > DIM_W'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = r_src_width;
        end
        priority if (r_src_height < DIM_W'(2)) begin
            h = DIM_W'(2);
        end else if (r_src_height > DIM_W'(MAX_HEIGHT)) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = r_src_height;
        end
    end

    assign half_w = w[DIM_W-1:1];
    assign half_h = h[DIM_W-1:1];

    assign out_blocked = r_out_valid && i_out_stall;
    assign o_in_stall  = r_s1_valid && out_blocked;
    assign in_acc      = i_in_valid && !o_in_stall;

    // Position of this pixel after frame start and any geometry shrink.
    always_comb begin
        c0     = i_in_data.frame_start ? '0 : r_col;
        r0     = i_in_data.frame_start ? '0 : r_row;
        c_wrap = DIM_W'(c0) >= w;
        c1     = c_wrap ? '0 : c0;
        r1     = c_wrap ? ({1'b0, r0} + 1'b1) : {1'b0, r0};
        r2     = (DIM_W'(r1) >= h) ? '0 : r1[ROW_W-1:0];
    end

    assign odd_col  = c1[0];
    assign blk      = c1[COL_W-1:1];
    assign drow     = DST_W'(r2[ROW_W-1:1]);
    assign pair     = {1'b0, r_held} + {1'b0, i_in_data.pixel};
    assign in_range = (DIM_W-1)'(blk) < half_w;
    assign row_ok   = (DIM_W-1)'(drow) < half_h;
    assign we_flag  = odd_col && in_range && !r2[0];
    assign re_flag  = odd_col && in_range && r2[0] && row_ok;

    always_comb begin
        c_inc = {1'b0, c1} + 1'b1;
        r3    = {1'b0, r2} + 1'b1;
        if (DIM_W'(c_inc) >= w) begin
            n_col = '0;
            n_row = (DIM_W'(r3) >= h) ? '0 : r3[ROW_W-1:0];
        end else begin
            n_col = c_inc[COL_W-1:0];
            n_row = r2;
        end
    end

    always_comb begin
        ram_req.we    = in_acc && we_flag;
        ram_req.re    = in_acc && re_flag;
        ram_req.addr  = blk;
        ram_req.wdata = pair;
    end

    bds_line_ram #(
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_W'(640);
            r_src_height <= DIM_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                default:        r_src_width  <= r_src_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!odd_col) begin
                r_held <= i_in_data.pixel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= re_flag;
        end else if (!out_blocked) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && re_flag) begin
            r_s1_pair <= pair;
            r_s1_dcol <= DST_W'(half_w - (DIM_W-1)'(blk) - 1'b1);
            r_s1_drow <= drow;
            r_s1_last <= ((DIM_W-1)'(blk) == half_w - 1'b1)
                      && ((DIM_W-1)'(drow) == half_h - 1'b1);
        end
    end

    assign sum4 = {1'b0, rdata} + {1'b0, r_s1_pair};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_blocked) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_blocked && r_s1_valid) begin
            r_out.avg_pixel <= sum4[SUM_W:2];
            r_out.dst_col   <= r_s1_dcol;
            r_out.dst_row   <= r_s1_drow;
            r_out.last      <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BDS_ASSERT_ALWAYS(a_ram_one_access, !(ram_req.we && ram_req.re), "line store read and write together")
    `BDS_ASSERT_NEXT(a_read_fills_s1, ram_req.re, r_s1_valid, "line store read lost its result")
    `BDS_ASSERT_ALWAYS(a_last_at_col0, !(o_out_valid && o_out_data.last) || (o_out_data.dst_col == '0), "last flag off the mirrored edge")
    `BDS_ASSERT_NEXT(a_out_drains, r_out_valid && !i_out_stall && !r_s1_valid, !r_out_valid, "output repeated")

endmodule

`default_nettype wire

### verif/tb_box_downsample_2x2_mirror.sv
// ----------------------------------------------------------------------------
// Testbench for the 2x2 box downsampler with mirrored columns
// Streams grey pixels through the valid/stall input channel while the output
// channel stalls at random, predicts each averaged block in the testbench and
// checks every field of every result in order. The run covers the geometry
// registers at reset values, clamped and small sizes, shrinking mid-frame,
// restarts, trailing odd columns and rows, and random frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_box_downsample_2x2_mirror;
    import bds_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 160;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_req          in_data   = '0;
    logic             out_stall = 1'b0;
    logic             cfg_we    = 1'b0;
    t_cfg_idx         cfg_idx   = CFG_SRC_WIDTH;
    logic [DIM_W-1:0] cfg_data  = '0;
    logic             in_stall;
    logic             out_valid;
    t_out_req         out_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // Predicted frame position, held pixel, pair-sum line and geometry.
    logic [DIM_W-1:0] geom_width  = DIM_W'(640);
    logic [DIM_W-1:0] geom_height = DIM_W'(480);
    int unsigned      pos_col     = 0;
    int unsigned      pos_row     = 0;
    logic [PIX_W-1:0] left_pixel  = '0;
    logic [SUM_W-1:0] pair_line [LINE_DEPTH];
    t_out_req         pending_averages [$];

    box_downsample_2x2_mirror u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < 2) begin
            return 2;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    task automatic predict_block_average(input t_in_req item);
        int unsigned      w;
        int unsigned      h;
        int unsigned      half_w;
        int unsigned      half_h;
        int unsigned      blk;
        int unsigned      drow;
        logic [SUM_W-1:0] pair;
        logic [SUM_W:0]   sum;
        t_out_req         avg;
        w      = clamp_dim(geom_width, MAX_WIDTH);
        h      = clamp_dim(geom_height, MAX_HEIGHT);
        half_w = w >> 1;
        half_h = h >> 1;
        if (item.frame_start) begin
            pos_col = 0;
            pos_row = 0;
        end
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) begin
            pos_row = 0;
        end
        if (pos_col % 2 == 0) begin
            left_pixel = item.pixel;
        end else begin
            blk  = pos_col >> 1;
            pair = {1'b0, left_pixel} + {1'b0, item.pixel};
            if (blk < half_w && blk < LINE_DEPTH) begin
                if (pos_row % 2 == 0) begin
                    pair_line[blk] = pair;
                end else if ((pos_row >> 1) < half_h) begin
                    drow          = pos_row >> 1;
                    sum           = {1'b0, pair_line[blk]} + {1'b0, pair};
                    avg.avg_pixel = sum[SUM_W:2];
                    avg.dst_col   = DST_W'(half_w - blk - 1);
                    avg.dst_row   = DST_W'(drow);
                    avg.last      = (blk == half_w - 1) && (drow == half_h - 1);
                    pending_averages.push_back(avg);
                end
            end
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) begin
                pos_row = 0;
            end
        end
    endtask

    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s expected %0d actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    task automatic check_average(input t_out_req got);
        t_out_req exp_avg;
        if (pending_averages.size() == 0) begin
            $error("unexpected result: avg_pixel %0d dst_col %0d dst_row %0d last %0d",
                   got.avg_pixel, got.dst_col, got.dst_row, got.last);
            fail_count++;
        end else begin
            exp_avg = pending_averages.pop_front();
            compare_field("avg_pixel", exp_avg.avg_pixel, got.avg_pixel);
            compare_field("dst_col", exp_avg.dst_col, got.dst_col);
            compare_field("dst_row", exp_avg.dst_row, got.dst_row);
            compare_field("last", exp_avg.last, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            check_average(out_data);
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic send_pixel(input t_in_req item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        predict_block_average(item);
    endtask

    // A negative fill gives random pixels with the extremes weighted up.
    task automatic send_run(input int count, input bit start_frame, input int fill,
                            input int fs_noise_pct);
        t_in_req item;
        for (int k = 0; k < count; k++) begin
            item.frame_start = (k == 0) ? start_frame
                                        : ($urandom_range(0, 99) < fs_noise_pct);
            if (fill >= 0) begin
                item.pixel = PIX_W'(fill);
            end else begin
                case ($urandom_range(0, 9))
                    0: item.pixel = '0;
                    1: item.pixel = '1;
                    default: item.pixel = PIX_W'($urandom_range(0, 255));
                endcase
            end
            send_pixel(item);
        end
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int w, input int h);
        wait_for_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SRC_WIDTH;
        cfg_data <= DIM_W'(w);
        @(posedge i_clk);
        cfg_idx  <= CFG_SRC_HEIGHT;
        cfg_data <= DIM_W'(h);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        geom_width  = DIM_W'(w);
        geom_height = DIM_W'(h);
    endtask

    task automatic test_reset_geometry();
        send_run(16, 1'b1, -1, 0);
    endtask

    task automatic test_extreme_pixels();
        set_geometry(2, 2);
        send_run(4, 1'b1, 255, 0);
        send_run(4, 1'b1, 0, 0);
        send_run(3, 1'b1, 255, 0);
        send_run(1, 1'b0, 254, 0);
        set_geometry(0, 1);
        send_run(4, 1'b1, -1, 0);
    endtask

    task automatic test_trailing_and_restart();
        set_geometry(5, 3);
        send_run(15, 1'b1, -1, 0);
        set_geometry(4, 4);
        send_run(6, 1'b1, -1, 0);
        send_run(16, 1'b1, -1, 0);
    endtask

    task automatic test_shrink_midframe();
        set_geometry(8, 8);
        send_run(14, 1'b1, -1, 0);
        set_geometry(4, 8);
        send_run(8, 1'b0, -1, 0);
        set_geometry(4, 2);
        send_run(8, 1'b0, -1, 0);
    endtask

    task automatic test_clamp_extremes();
        set_geometry(2047, 0);
        send_run(16, 1'b1, -1, 0);
        set_geometry(2, 2047);
        send_run(8, 1'b1, -1, 0);
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        int sent;
        int frames;
        int area;
        int count;
        bit start;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 64;
                end
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    w = $urandom_range(2, 10);
                    h = $urandom_range(2, 10);
                end else begin
                    w = $urandom_range(11, 64);
                    h = $urandom_range(2, 6);
                end
                set_geometry(w, h);
                frames = $urandom_range(1, 3);
                area   = w * h;
                for (int f = 0; f < frames; f++) begin
                    count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, area) : area;
                    if (count > PHASE_ITEMS - sent) begin
                        count = PHASE_ITEMS - sent;
                    end
                    start = (f == 0) || ($urandom_range(0, 9) < 7);
                    send_run(count, start, -1, 2);
                    sent += count;
                end
            end
        end
    endtask

    initial begin
        send_idle_pct = 28;
        recv_idle_pct = 64;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_extreme_pixels();
        test_trailing_and_restart();
        test_shrink_midframe();
        test_clamp_extremes();

        test_random_frames();

        wait_for_idle();
        if (fail_count == 0 && pending_averages.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
